[hw/rtl/alt_pkg.sv]
// alt_pkg: shared types and constants for the activity lease table
// depends on nothing; imported by activity_lease_table_top and the testbench

package alt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = 5;

    typedef enum logic [2:0] {
        CMD_ACQUIRE     = 3'd0,
        CMD_RELEASE     = 3'd1,
        CMD_CLAIM       = 3'd2,
        CMD_REL_MASTER  = 3'd3,
        CMD_QUERY       = 3'd4,
        CMD_COUNT       = 3'd5,
        CMD_TICK        = 3'd6,
        CMD_CLEAR       = 3'd7
    } cmd_t;

    localparam logic [2:0] ACT_IDLE    = 3'd0;
    localparam logic [2:0] ACT_GRIND   = 3'd1;
    localparam logic [2:0] ACT_TRADING = 3'd2;
    localparam logic [2:0] ACT_LFT     = 3'd3;
    localparam logic [2:0] ACT_BG      = 3'd4;
    localparam logic [2:0] ACT_MASTER  = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD,
        ST_EVAL,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [31:0] bot_id;
        logic [2:0]  activity;
        logic [31:0] granted_at;
        logic [31:0] limit_ms;
    } entry_t;

    typedef struct packed {
        logic             status_ok;
        logic [2:0]       activity_now;
        logic [31:0]      remaining_ms;
        logic             evicted;
        logic [31:0]      evicted_bot_id;
        logic [2:0]       evicted_activity;
        logic [CNT_W-1:0] count_grinding;
        logic [CNT_W-1:0] count_trading;
        logic [CNT_W-1:0] count_lft;
        logic [CNT_W-1:0] count_bg;
        logic [CNT_W-1:0] count_master;
        logic             last;
    } beat_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        sat_inc = (c == {CNT_W{1'b1}}) ? c : c + CNT_W'(1);
    endfunction

endpackage

[hw/rtl/activity_lease_table_top.sv]
// activity_lease_table_top: keyed lease table, one activity per agent id
// depends on alt_pkg; holds the entry memory and the scan sequencer
//
//  channel | ports                         | role
//  --------+-------------------------------+-----------------------------------
//  input   | s_valid/s_ready, s_<field>    | one command beat per item
//  result  | m_valid/m_ready, m_<field>    | 1 beat, or evictions + closing beat
//
// steps: every command except clear walks the table, a registered memory
//   read then an evaluate per entry, plus the accept state and the finish
//   state, and a new command is accepted only back in idle; lookups stop
//   at the matching entry; clear goes from the accept straight to finish
// the single read port of the entry memory keeps the walk to one entry at a time
// reset: synchronous active-low aresetn clears valid bits, clock and control
// stalls: the result register frees the sequencer once a beat is taken;
//   on a stalled m_ready the scan waits at the beat it wants to emit

module activity_lease_table_top
    import alt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_command,
    input  logic [31:0]       s_bot_id,
    input  logic [2:0]        s_activity,
    input  logic              s_restore_grinding,
    input  logic [31:0]       s_duration_ms,
    input  logic [31:0]       s_tick_ms,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_status_ok,
    output logic [2:0]        m_activity_now,
    output logic [31:0]       m_remaining_ms,
    output logic              m_evicted,
    output logic [31:0]       m_evicted_bot_id,
    output logic [2:0]        m_evicted_activity,
    output logic [CNT_W-1:0]  m_count_grinding,
    output logic [CNT_W-1:0]  m_count_trading,
    output logic [CNT_W-1:0]  m_count_lft,
    output logic [CNT_W-1:0]  m_count_bg,
    output logic [CNT_W-1:0]  m_count_master,
    output logic              m_last
);

    // entry memory, one read and one write port
    entry_t mem [TABLE_ENTRIES];
    entry_t rdata_reg;

    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    entry_t                   wr_data;

    state_t state_reg, state_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [31:0]              clock_reg, clock_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;

    // latched command
    cmd_t        cmd_reg, cmd_next;
    logic [31:0] id_reg, id_next;
    logic [2:0]  act_reg, act_next;
    logic        rg_reg, rg_next;
    logic [31:0] dur_reg, dur_next;

    // lookup results
    logic             found_reg, found_next;
    logic [IDX_W-1:0] fidx_reg, fidx_next;
    entry_t           ent_reg, ent_next;
    logic [31:0]      el_reg, el_next;
    logic             free_reg, free_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;

    logic [CNT_W-1:0] cg_reg, ct_reg, cl_reg, cb_reg, cm_reg;
    logic [CNT_W-1:0] cg_next, ct_next, cl_next, cb_next, cm_next;

    beat_t out_reg, out_next;
    logic  m_valid_reg, m_valid_next;

    logic        out_free;
    logic        last_idx;
    logic        hit;
    logic [31:0] age;
    beat_t       beat;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[idx_reg];
    end

    assign out_free = !m_valid_reg || m_ready;
    assign last_idx = (idx_reg == IDX_W'(TABLE_ENTRIES - 1));
    assign hit      = valid_reg[idx_reg] && (rdata_reg.bot_id == id_reg);
    assign age      = clock_reg - rdata_reg.granted_at;
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        clock_next    = clock_reg;
        idx_next      = idx_reg;
        cmd_next      = cmd_reg;
        id_next       = id_reg;
        act_next      = act_reg;
        rg_next       = rg_reg;
        dur_next      = dur_reg;
        found_next    = found_reg;
        fidx_next     = fidx_reg;
        ent_next      = ent_reg;
        el_next       = el_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        cg_next       = cg_reg;
        ct_next       = ct_reg;
        cl_next       = cl_reg;
        cb_next       = cb_reg;
        cm_next       = cm_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        wr_en         = 1'b0;
        wr_addr       = fidx_reg;
        wr_data       = '{bot_id: id_reg, activity: act_reg, granted_at: clock_reg,
                          limit_ms: dur_reg};
        beat          = '0;
        beat.last     = 1'b1;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next   = cmd_t'(s_command);
                    id_next    = s_bot_id;
                    act_next   = s_activity;
                    rg_next    = s_restore_grinding;
                    dur_next   = s_duration_ms;
                    idx_next   = '0;
                    found_next = 1'b0;
                    free_next  = 1'b0;
                    cg_next    = '0;
                    ct_next    = '0;
                    cl_next    = '0;
                    cb_next    = '0;
                    cm_next    = '0;
                    if (cmd_t'(s_command) == CMD_TICK) begin
                        clock_next = clock_reg + s_tick_ms;
                    end
                    state_next = (cmd_t'(s_command) == CMD_CLEAR) ? ST_FINISH : ST_RD;
                end
            end
            ST_RD: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (cmd_reg == CMD_TICK) begin
                    if (valid_reg[idx_reg] && rdata_reg.limit_ms != '0 &&
                        age > rdata_reg.limit_ms) begin
                        if (out_free) begin
                            beat.last             = 1'b0;
                            beat.evicted          = 1'b1;
                            beat.evicted_bot_id   = rdata_reg.bot_id;
                            beat.evicted_activity = rdata_reg.activity;
                            out_next              = beat;
                            m_valid_next          = 1'b1;
                            valid_next[idx_reg]   = 1'b0;
                            idx_next              = idx_reg + IDX_W'(1);
                            state_next            = last_idx ? ST_FINISH : ST_RD;
                        end
                    end else begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = last_idx ? ST_FINISH : ST_RD;
                    end
                end else if (cmd_reg == CMD_COUNT) begin
                    if (valid_reg[idx_reg]) begin
                        case (rdata_reg.activity)
                            ACT_GRIND:   cg_next = sat_inc(cg_reg);
                            ACT_TRADING: ct_next = sat_inc(ct_reg);
                            ACT_LFT:     cl_next = sat_inc(cl_reg);
                            ACT_BG:      cb_next = sat_inc(cb_reg);
                            ACT_MASTER:  cm_next = sat_inc(cm_reg);
                            default:     ;
                        endcase
                    end
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = last_idx ? ST_FINISH : ST_RD;
                end else begin
                    if (hit) begin
                        found_next = 1'b1;
                        fidx_next  = idx_reg;
                        ent_next   = rdata_reg;
                        el_next    = age;
                        state_next = ST_FINISH;
                    end else begin
                        if (!valid_reg[idx_reg] && !free_reg) begin
                            free_next     = 1'b1;
                            free_idx_next = idx_reg;
                        end
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = last_idx ? ST_FINISH : ST_RD;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    case (cmd_reg)
                        CMD_ACQUIRE: begin
                            if (id_reg != '0 && act_reg >= ACT_GRIND && act_reg <= ACT_BG) begin
                                if (!found_reg) begin
                                    if (free_reg) begin
                                        wr_en          = 1'b1;
                                        wr_addr        = free_idx_reg;
                                        beat.status_ok = 1'b1;
                                    end
                                end else if (ent_reg.activity == ACT_IDLE ||
                                             ent_reg.activity == act_reg) begin
                                    wr_en          = 1'b1;
                                    beat.status_ok = 1'b1;
                                end else if (ent_reg.activity == ACT_GRIND) begin
                                    wr_en                 = 1'b1;
                                    beat.status_ok        = 1'b1;
                                    beat.evicted          = 1'b1;
                                    beat.evicted_bot_id   = id_reg;
                                    beat.evicted_activity = ACT_GRIND;
                                end
                            end
                        end
                        CMD_RELEASE: begin
                            if (found_reg && ent_reg.activity == act_reg) begin
                                beat.status_ok = 1'b1;
                                if (rg_reg) begin
                                    wr_en            = 1'b1;
                                    wr_data.activity = ACT_GRIND;
                                    wr_data.limit_ms = '0;
                                end else begin
                                    valid_next[fidx_reg] = 1'b0;
                                end
                            end
                        end
                        CMD_CLAIM: begin
                            wr_data.activity = ACT_MASTER;
                            wr_data.limit_ms = '0;
                            if (id_reg != '0) begin
                                if (found_reg) begin
                                    wr_en          = 1'b1;
                                    beat.status_ok = 1'b1;
                                    if (ent_reg.activity != ACT_IDLE &&
                                        ent_reg.activity != ACT_MASTER) begin
                                        beat.evicted          = 1'b1;
                                        beat.evicted_bot_id   = id_reg;
                                        beat.evicted_activity = ent_reg.activity;
                                    end
                                end else if (free_reg) begin
                                    wr_en          = 1'b1;
                                    wr_addr        = free_idx_reg;
                                    beat.status_ok = 1'b1;
                                end
                            end
                        end
                        CMD_REL_MASTER: begin
                            if (found_reg && ent_reg.activity == ACT_MASTER) begin
                                valid_next[fidx_reg] = 1'b0;
                                beat.status_ok       = 1'b1;
                            end
                        end
                        CMD_QUERY: begin
                            if (found_reg) begin
                                beat.activity_now = ent_reg.activity;
                                if (ent_reg.limit_ms != '0 && el_reg < ent_reg.limit_ms) begin
                                    beat.remaining_ms = ent_reg.limit_ms - el_reg;
                                end
                            end
                        end
                        CMD_COUNT: begin
                            beat.count_grinding = cg_reg;
                            beat.count_trading  = ct_reg;
                            beat.count_lft      = cl_reg;
                            beat.count_bg       = cb_reg;
                            beat.count_master   = cm_reg;
                        end
                        CMD_TICK: begin
                            // closing beat after any evictions
                        end
                        CMD_CLEAR: begin
                            valid_next = '0;
                            clock_next = '0;
                        end
                        default: ;
                    endcase
                    if (wr_en) begin
                        valid_next[wr_addr] = 1'b1;
                    end
                    out_next     = beat;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            clock_reg   <= '0;
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            clock_reg   <= clock_next;
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        id_reg       <= id_next;
        act_reg      <= act_next;
        rg_reg       <= rg_next;
        dur_reg      <= dur_next;
        found_reg    <= found_next;
        fidx_reg     <= fidx_next;
        ent_reg      <= ent_next;
        el_reg       <= el_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
        cg_reg       <= cg_next;
        ct_reg       <= ct_next;
        cl_reg       <= cl_next;
        cb_reg       <= cb_next;
        cm_reg       <= cm_next;
        out_reg      <= out_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_status_ok        = out_reg.status_ok;
    assign m_activity_now     = out_reg.activity_now;
    assign m_remaining_ms     = out_reg.remaining_ms;
    assign m_evicted          = out_reg.evicted;
    assign m_evicted_bot_id   = out_reg.evicted_bot_id;
    assign m_evicted_activity = out_reg.evicted_activity;
    assign m_count_grinding   = out_reg.count_grinding;
    assign m_count_trading    = out_reg.count_trading;
    assign m_count_lft        = out_reg.count_lft;
    assign m_count_bg         = out_reg.count_bg;
    assign m_count_master     = out_reg.count_master;
    assign m_last             = out_reg.last;

    // finishing a command always leaves a closing beat behind
    a_finish_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && out_free) |=> (m_valid && m_last))
        else $error("closing beat missing");

    // no new item is taken right after one was accepted
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("accepted while busy");

    // clear empties the table and the clock
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && cmd_reg == CMD_CLEAR && out_free)
        |=> (valid_reg == '0 && clock_reg == '0))
        else $error("clear incomplete");

    // a beat that is not the last one reports an eviction
    a_mid_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |-> m_evicted)
        else $error("intermediate beat without eviction");

endmodule

[tb/sv/activity_lease_table_scoreboard.sv]
// activity_lease_table_scoreboard: watches both channels of the lease table,
// predicts result beats and compares them; depends on alt_pkg
module activity_lease_table_scoreboard
    import alt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [2:0]        s_command,
    input  logic [31:0]       s_bot_id,
    input  logic [2:0]        s_activity,
    input  logic              s_restore_grinding,
    input  logic [31:0]       s_duration_ms,
    input  logic [31:0]       s_tick_ms,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic              m_status_ok,
    input  logic [2:0]        m_activity_now,
    input  logic [31:0]       m_remaining_ms,
    input  logic              m_evicted,
    input  logic [31:0]       m_evicted_bot_id,
    input  logic [2:0]        m_evicted_activity,
    input  logic [CNT_W-1:0]  m_count_grinding,
    input  logic [CNT_W-1:0]  m_count_trading,
    input  logic [CNT_W-1:0]  m_count_lft,
    input  logic [CNT_W-1:0]  m_count_bg,
    input  logic [CNT_W-1:0]  m_count_master,
    input  logic              m_last,
    output int                pending,
    output int                errors
);

    logic        lease_used [TABLE_ENTRIES];
    logic [31:0] lease_id   [TABLE_ENTRIES];
    logic [2:0]  lease_act  [TABLE_ENTRIES];
    logic [31:0] lease_t0   [TABLE_ENTRIES];
    logic [31:0] lease_lim  [TABLE_ENTRIES];
    logic [31:0] now_ms;
    beat_t       expected_beats [$];

    function automatic int find_id(logic [31:0] id);
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (lease_used[i] && lease_id[i] == id) return i;
        return -1;
    endfunction

    function automatic int find_free();
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (!lease_used[i]) return i;
        return -1;
    endfunction

    function automatic void grant(int s, logic [31:0] id, logic [2:0] a, logic [31:0] lim);
        lease_used[s] = 1'b1;
        lease_id[s]   = id;
        lease_act[s]  = a;
        lease_t0[s]   = now_ms;
        lease_lim[s]  = lim;
    endfunction

    function automatic int sat(int v);
        return v > 31 ? 31 : v;
    endfunction

    // apply one command beat to the shadow table and queue its results
    function automatic void apply_command(cmd_t cmd, logic [31:0] id, logic [2:0] a,
                                          logic rg, logic [31:0] dur, logic [31:0] tk);
        beat_t r;
        beat_t ev;
        int s;
        int f;
        int cnt [6];
        logic [31:0] el;
        r = '0;
        case (cmd)
            CMD_ACQUIRE: begin
                if (id != 0 && a >= ACT_GRIND && a <= ACT_BG) begin
                    s = find_id(id);
                    if (s < 0) begin
                        f = find_free();
                        if (f >= 0) begin
                            grant(f, id, a, dur);
                            r.status_ok = 1'b1;
                        end
                    end else if (lease_act[s] == ACT_IDLE) begin
                        grant(s, id, a, dur);
                        r.status_ok = 1'b1;
                    end else if (lease_act[s] == a) begin
                        lease_t0[s]  = now_ms;
                        lease_lim[s] = dur;
                        r.status_ok  = 1'b1;
                    end else if (lease_act[s] == ACT_GRIND) begin
                        r.evicted          = 1'b1;
                        r.evicted_bot_id   = id;
                        r.evicted_activity = ACT_GRIND;
                        grant(s, id, a, dur);
                        r.status_ok = 1'b1;
                    end
                end
            end
            CMD_RELEASE: begin
                s = find_id(id);
                if (s >= 0 && lease_act[s] == a) begin
                    if (rg) grant(s, id, ACT_GRIND, '0);
                    else lease_used[s] = 1'b0;
                    r.status_ok = 1'b1;
                end
            end
            CMD_CLAIM: begin
                if (id != 0) begin
                    s = find_id(id);
                    if (s >= 0) begin
                        if (lease_act[s] != ACT_IDLE && lease_act[s] != ACT_MASTER) begin
                            r.evicted          = 1'b1;
                            r.evicted_bot_id   = id;
                            r.evicted_activity = lease_act[s];
                        end
                        grant(s, id, ACT_MASTER, '0);
                        r.status_ok = 1'b1;
                    end else begin
                        f = find_free();
                        if (f >= 0) begin
                            grant(f, id, ACT_MASTER, '0);
                            r.status_ok = 1'b1;
                        end
                    end
                end
            end
            CMD_REL_MASTER: begin
                s = find_id(id);
                if (s >= 0 && lease_act[s] == ACT_MASTER) begin
                    lease_used[s] = 1'b0;
                    r.status_ok   = 1'b1;
                end
            end
            CMD_QUERY: begin
                s = find_id(id);
                if (s >= 0) begin
                    r.activity_now = lease_act[s];
                    if (lease_lim[s] != 0) begin
                        el = now_ms - lease_t0[s];
                        if (el < lease_lim[s]) r.remaining_ms = lease_lim[s] - el;
                    end
                end
            end
            CMD_COUNT: begin
                foreach (cnt[k]) cnt[k] = 0;
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (lease_used[i] && lease_act[i] <= ACT_MASTER) cnt[lease_act[i]]++;
                r.count_grinding = CNT_W'(sat(cnt[ACT_GRIND]));
                r.count_trading  = CNT_W'(sat(cnt[ACT_TRADING]));
                r.count_lft      = CNT_W'(sat(cnt[ACT_LFT]));
                r.count_bg       = CNT_W'(sat(cnt[ACT_BG]));
                r.count_master   = CNT_W'(sat(cnt[ACT_MASTER]));
            end
            CMD_TICK: begin
                now_ms = now_ms + tk;
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (lease_used[i] && lease_lim[i] != 0 &&
                        (now_ms - lease_t0[i]) > lease_lim[i]) begin
                        ev = '0;
                        ev.evicted          = 1'b1;
                        ev.evicted_bot_id   = lease_id[i];
                        ev.evicted_activity = lease_act[i];
                        lease_used[i] = 1'b0;
                        expected_beats = {expected_beats, ev};
                    end
                end
            end
            default: begin
                foreach (lease_used[k]) lease_used[k] = 1'b0;
                now_ms = '0;
            end
        endcase
        r.last = 1'b1;
        expected_beats = {expected_beats, r};
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        beat_t e;
        if (!aresetn) begin
            errors = 0;
            now_ms = '0;
            foreach (lease_used[k]) lease_used[k] = 1'b0;
            expected_beats.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_beats.size() == 0) begin
                    $error("result beat with nothing expected");
                    errors++;
                end else begin
                    e = expected_beats.pop_front();
                    check_field("status_ok", 32'(e.status_ok), 32'(m_status_ok));
                    check_field("activity_now", 32'(e.activity_now), 32'(m_activity_now));
                    check_field("remaining_ms", e.remaining_ms, m_remaining_ms);
                    check_field("evicted", 32'(e.evicted), 32'(m_evicted));
                    check_field("evicted_bot_id", e.evicted_bot_id, m_evicted_bot_id);
                    check_field("evicted_activity", 32'(e.evicted_activity),
                                32'(m_evicted_activity));
                    check_field("count_grinding", 32'(e.count_grinding),
                                32'(m_count_grinding));
                    check_field("count_trading", 32'(e.count_trading), 32'(m_count_trading));
                    check_field("count_lft", 32'(e.count_lft), 32'(m_count_lft));
                    check_field("count_bg", 32'(e.count_bg), 32'(m_count_bg));
                    check_field("count_master", 32'(e.count_master), 32'(m_count_master));
                    check_field("last", 32'(e.last), 32'(m_last));
                end
            end
            if (s_valid && s_ready)
                apply_command(cmd_t'(s_command), s_bot_id, s_activity, s_restore_grinding,
                              s_duration_ms, s_tick_ms);
        end
        pending <= expected_beats.size();
    end

endmodule

[tb/sv/activity_lease_table_top_test.sv]
// activity_lease_table_top_test: stimulus, handshake idling and verdict for
// the lease table; depends on alt_pkg and activity_lease_table_scoreboard
module activity_lease_table_top_test;
    import alt_pkg::*;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [2:0]        s_command;
    logic [31:0]       s_bot_id;
    logic [2:0]        s_activity;
    logic              s_restore_grinding;
    logic [31:0]       s_duration_ms;
    logic [31:0]       s_tick_ms;
    logic              m_valid;
    logic              m_ready;
    logic              m_status_ok;
    logic [2:0]        m_activity_now;
    logic [31:0]       m_remaining_ms;
    logic              m_evicted;
    logic [31:0]       m_evicted_bot_id;
    logic [2:0]        m_evicted_activity;
    logic [CNT_W-1:0]  m_count_grinding;
    logic [CNT_W-1:0]  m_count_trading;
    logic [CNT_W-1:0]  m_count_lft;
    logic [CNT_W-1:0]  m_count_bg;
    logic [CNT_W-1:0]  m_count_master;
    logic              m_last;
    int                pending;
    int                errors;

    // idle percentages for sender and receiver, changed per phase
    int sender_gap_pct;
    int sink_stall_pct;

    activity_lease_table_top dut (.*);
    activity_lease_table_scoreboard checker_i (.*);

    // 12 unit clock
    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // receiver: stalls at random, one decision per edge
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // small pool of agent ids so that commands hit existing leases;
    // a few extreme ids keep every bit of the id toggling
    function automatic logic [31:0] pick_id();
        int r;
        r = $urandom_range(99);
        if (r < 3) return 32'd0;
        if (r < 6) return 32'hFFFF_FFFF;
        if (r < 10) return $urandom;
        return 32'(1 + $urandom_range(19));
    endfunction

    // duration: mostly short so ticks expire leases, sometimes unlimited or huge
    function automatic logic [31:0] pick_dur();
        int r;
        r = $urandom_range(99);
        if (r < 15) return 32'd0;
        if (r < 22) return $urandom;
        if (r < 25) return 32'hFFFF_FFFF;
        return 32'($urandom_range(1, 400));
    endfunction

    // one command beat; valid held until accepted, payload unchanged meanwhile
    task automatic send(cmd_t cmd, logic [31:0] id, logic [2:0] act, logic rg,
                        logic [31:0] dur, logic [31:0] tk);
        while ($urandom_range(99) < sender_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_command          <= cmd;
        s_bot_id           <= id;
        s_activity         <= act;
        s_restore_grinding <= rg;
        s_duration_ms      <= dur;
        s_tick_ms          <= tk;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_random();
        int r;
        logic [31:0] tk;
        r = $urandom_range(99);
        tk = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(200));
        // weighted toward acquire/tick/query; tick often enough to age leases
        if (r < 30)
            send(CMD_ACQUIRE, pick_id(), 3'($urandom_range(7)), 1'($urandom), pick_dur(),
                 $urandom);
        else if (r < 42)
            send(CMD_RELEASE, pick_id(), 3'($urandom_range(7)), 1'($urandom), $urandom,
                 $urandom);
        else if (r < 50)
            send(CMD_CLAIM, pick_id(), 3'($urandom), 1'($urandom), $urandom, $urandom);
        else if (r < 56)
            send(CMD_REL_MASTER, pick_id(), 3'($urandom), 1'($urandom), $urandom, $urandom);
        else if (r < 70)
            send(CMD_QUERY, pick_id(), 3'($urandom), 1'($urandom), $urandom, $urandom);
        else if (r < 78)
            send(CMD_COUNT, pick_id(), 3'($urandom), 1'($urandom), $urandom, $urandom);
        else if (r < 99)
            send(CMD_TICK, $urandom, 3'($urandom), 1'($urandom), $urandom, tk);
        else
            send(CMD_CLEAR, $urandom, 3'($urandom), 1'($urandom), $urandom, $urandom);
    endtask

    initial begin
        int waited;
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_command          = CMD_QUERY;
        s_bot_id           = '0;
        s_activity         = ACT_IDLE;
        s_restore_grinding = 1'b0;
        s_duration_ms      = '0;
        s_tick_ms          = '0;
        sender_gap_pct     = 10;
        sink_stall_pct     = 46;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: refusals, every command, preemption, expiry, wrap, full table
        send(CMD_ACQUIRE, 32'd0, ACT_GRIND, 1'b0, 32'd5, '0);           // id 0 refused
        send(CMD_ACQUIRE, 32'd7, ACT_IDLE, 1'b0, 32'd5, '0);            // idle refused
        send(CMD_ACQUIRE, 32'd7, ACT_MASTER, 1'b0, 32'd5, '0);          // master refused
        send(CMD_ACQUIRE, 32'd7, 3'd6, 1'b0, 32'd5, '0);                // unknown refused
        send(CMD_ACQUIRE, 32'd7, ACT_GRIND, 1'b0, 32'd0, '0);
        send(CMD_ACQUIRE, 32'd7, ACT_TRADING, 1'b0, 32'd50, '0);        // preempts grinding
        send(CMD_ACQUIRE, 32'd7, ACT_LFT, 1'b0, 32'd50, '0);            // excluded
        send(CMD_ACQUIRE, 32'd7, ACT_TRADING, 1'b0, 32'd100, '0);       // renew
        send(CMD_QUERY, 32'd7, ACT_IDLE, 1'b0, '0, '0);
        send(CMD_CLAIM, 32'hFFFF_FFFF, ACT_MASTER, 1'b1, '1, '1);
        send(CMD_CLAIM, 32'd7, ACT_IDLE, 1'b0, '0, '0);                 // displaces trading
        send(CMD_RELEASE, 32'd7, 3'd7, 1'b1, '0, '0);                   // never matches
        send(CMD_REL_MASTER, 32'd7, ACT_IDLE, 1'b0, '0, '0);
        send(CMD_REL_MASTER, 32'd9, ACT_IDLE, 1'b0, '0, '0);            // absent
        send(CMD_ACQUIRE, 32'd8, ACT_BG, 1'b0, 32'hFFFF_FFFF, '0);
        send(CMD_RELEASE, 32'd8, ACT_BG, 1'b1, '0, '0);                 // back to grinding
        for (int i = 0; i < TABLE_ENTRIES + 1; i++)                     // fill past full
            send(CMD_ACQUIRE, 32'(100 + i), 3'(1 + i % 4), 1'b0, 32'(10 + i), '0);
        send(CMD_COUNT, '0, '0, '0, '0, '0);
        send(CMD_TICK, '0, '0, '0, '0, 32'd20);                         // several expire
        send(CMD_TICK, '0, '0, '0, '0, 32'hFFFF_FFFF);                  // clock wraps
        send(CMD_RELEASE, 32'd8, ACT_GRIND, 1'b0, '0, '0);
        send(CMD_CLEAR, '1, '1, '1, '1, '1);
        send(CMD_COUNT, '0, '0, '0, '0, '0);

        // random, three idling phases
        for (int i = 0; i < 430; i++) begin
            if (i == 143) begin
                sender_gap_pct = 46;
                sink_stall_pct = 10;
            end else if (i == 287) begin
                sender_gap_pct = 0;
                sink_stall_pct = 0;
            end
            send_random();
        end
        s_valid <= 1'b0;

        // drain, then let a table walk pass for any stray beat
        waited = 0;
        while (pending != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (2 * TABLE_ENTRIES + 20) @(posedge aclk);
        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog, well past the slowest run
    initial begin
        #6000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
